### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ORF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ORF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/orf_pkg.sv
// Types, codes and helpers shared by the overwriting ring FIFO.
package orf_pkg;

  localparam int CNT_W = 6;
  localparam int VAL_W = 16;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] LEN_RESET = 6'd63;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERWRITE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        element_count;
  } out_res_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic cfg_load;
  } orf_cmd_t;

  // Ring length in effect: zero acts as one, capped below the store depth.
  function automatic logic [CNT_W-1:0] ring_len(input logic [CNT_W-1:0] len,
                                                input int depth);
    logic [CNT_W-1:0] n;
    n = (len == '0) ? CNT_W'(1) : len;
    if (int'(n) > depth - 1) begin
      n = CNT_W'(depth - 1);
    end
    return n;
  endfunction

endpackage

### rtl/orf_ctrl.sv
// Controller: accepts a request, runs its execute cycle, gates config writes.
module orf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cfg_valid,
  output logic              busy,
  output logic              cfg_ready,
  output orf_pkg::orf_cmd_t cmd
);
  import orf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r == S_EXEC);
  assign cfg_ready    = !busy && !start;
  assign cmd.capture  = start && !busy;
  assign cmd.execute  = busy;
  assign cmd.cfg_load = cfg_valid && cfg_ready;

endmodule

### rtl/orf_dp.sv
// Datapath: sample store, ring pointers, count and the result register.
module orf_dp #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  orf_pkg::orf_cmd_t            cmd,
  input  orf_pkg::in_req_t             in_req,
  input  logic [orf_pkg::CNT_W-1:0]    cfg_data,
  output logic                         out_strobe,
  output orf_pkg::out_res_t            out_res
);
  import orf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] eff_len, new_len;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] rdata_r;
  logic             out_strobe_r;
  out_res_t         out_res_r, res_nxt;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0] rd_ptr_inc, wr_ptr_inc;
  logic             full, empty;

  assign eff_len = ring_len(len_r, DEPTH);
  assign new_len = ring_len(cfg_data, DEPTH);
  assign full    = (cnt_r >= eff_len);
  assign empty   = (cnt_r == '0);

  assign rd_ptr_inc = (int'(rd_ptr_r) + 1 >= int'(eff_len)) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_inc = (int'(wr_ptr_r) + 1 >= int'(eff_len)) ? '0 : wr_ptr_r + 1'b1;

  always_comb begin
    len_nxt    = len_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_ptr_inc;
    mem_wdata  = val_r;
    res_nxt.status     = ST_OK;
    res_nxt.read_value = '0;
    if (cmd.cfg_load) begin
      len_nxt    = cfg_data;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = IDX_W'(new_len - 1'b1);
      cnt_nxt    = '0;
    end else if (cmd.execute) begin
      case (cmd_r)
        CMD_ENQ: begin
          mem_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_inc;
          if (full) begin
            res_nxt.status = ST_OVERWRITE;
            rd_ptr_nxt     = rd_ptr_inc;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        CMD_DEQ: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.read_value = rdata_r;
            mem_we     = 1'b1;
            mem_waddr  = rd_ptr_r;
            mem_wdata  = '0;
            rd_ptr_nxt = rd_ptr_inc;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        CMD_PEEK: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.read_value = rdata_r;
          end
        end
        default: begin
        end
      endcase
    end
    res_nxt.element_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.capture) begin
      rdata_r <= mem[rd_ptr_r];
      cmd_r   <= in_req.command;
      val_r   <= in_req.push_value;
    end
    if (cmd.execute) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= LEN_RESET;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= IDX_W'(ring_len(LEN_RESET, DEPTH) - 1'b1);
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= cmd.execute;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

### rtl/overwriting_ring_fifo.sv
// Top level of the overwriting ring FIFO of signed 16-bit samples.
// For each request busy is high for one cycle after start is
// taken while the registered store read finishes, and the result appears on
// out_res with out_strobe for exactly one cycle after that; a new request may
// be started in that same cycle. The receiver cannot stall, so capture
// out_res whenever out_strobe is high. Dequeue and peek report only entries
// written since the last length write, so no store clearing pass is needed.
// A config write is taken only while no request is in flight.
`include "assert_macros.svh"

module overwriting_ring_fifo #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  orf_pkg::in_req_t          in_req,
  output logic                      out_strobe,
  output orf_pkg::out_res_t         out_res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [orf_pkg::CNT_W-1:0] cfg_data
);
  import orf_pkg::*;

  orf_cmd_t cmd;

  orf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  orf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_req     (in_req),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  `ORF_ASSERT_NXT(a_req_busy, clk, rst_n, start && !busy, busy ##1 out_strobe)
  `ORF_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `ORF_ASSERT_IMP(a_empty_res, clk, rst_n, out_strobe && out_res.status == ST_EMPTY,
                  out_res.element_count == '0 && out_res.read_value == '0)
  `ORF_ASSERT_IMP(a_ovw_res, clk, rst_n, out_strobe && out_res.status == ST_OVERWRITE,
                  out_res.read_value == '0 && out_res.element_count != '0)

endmodule

### tb/tb_overwriting_ring_fifo.sv
// Self-checking testbench for the overwriting ring FIFO: directed and random requests.
`timescale 1ns / 100ps

module tb_overwriting_ring_fifo;
  import orf_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_req_t             in_req;
  logic                out_strobe;
  out_res_t            out_res;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data;

  logic signed [VAL_W-1:0] sample_mem [DEPTH];
  int                      head_idx;
  int                      tail_idx;
  int                      fill_count;
  logic [CNT_W-1:0]        ring_length_reg;

  out_res_t expected_results[$];
  int       sender_idle_pct;
  int       mismatch_count;
  int       cycle_count;
  int       request_count;
  int       overwrite_count;
  int       empty_count;
  int       length_write_count;

  overwriting_ring_fifo #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int ring_size();
    int n;
    n = (ring_length_reg == '0) ? 1 : int'(ring_length_reg);
    if (n > DEPTH - 1) begin
      n = DEPTH - 1;
    end
    return n;
  endfunction

  function automatic int ring_advance(input int idx);
    return (idx + 1 >= ring_size()) ? 0 : idx + 1;
  endfunction

  function automatic void load_ring_length(input logic [CNT_W-1:0] len);
    ring_length_reg = len;
    foreach (sample_mem[i]) begin
      sample_mem[i] = '0;
    end
    head_idx   = 0;
    tail_idx   = ring_size() - 1;
    fill_count = 0;
  endfunction

  function automatic out_res_t predict_fifo_result(input in_req_t req);
    out_res_t res;
    res.status     = ST_OK;
    res.read_value = '0;
    case (req.command)
      CMD_ENQ: begin
        tail_idx = ring_advance(tail_idx);
        sample_mem[tail_idx] = req.push_value;
        if (fill_count >= ring_size()) begin
          res.status = ST_OVERWRITE;
          head_idx = ring_advance(head_idx);
          overwrite_count++;
        end else begin
          fill_count++;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (fill_count == 0) begin
          res.status = ST_EMPTY;
          empty_count++;
        end else begin
          res.read_value = sample_mem[head_idx];
          if (req.command == CMD_DEQ) begin
            sample_mem[head_idx] = '0;
            head_idx = ring_advance(head_idx);
            fill_count--;
          end
        end
      end
      default: begin
      end
    endcase
    res.element_count = CNT_W'(fill_count);
    request_count++;
    return res;
  endfunction

  function automatic void note_mismatch(input out_res_t exp_res, input out_res_t got_res,
                                        input bit unexpected);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (unexpected) begin
        $display("%0t: result with nothing pending: status %0d value %0d count %0d",
                 $realtime, got_res.status, got_res.read_value, got_res.element_count);
      end else begin
        $display("%0t: expected status %0d value %0d count %0d, got %0d %0d %0d",
                 $realtime, exp_res.status, exp_res.read_value, exp_res.element_count,
                 got_res.status, got_res.read_value, got_res.element_count);
      end
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        note_mismatch(out_res, out_res, 1'b1);
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.status !== out_res.status || exp_res.read_value !== out_res.read_value ||
            exp_res.element_count !== out_res.element_count) begin
          note_mismatch(exp_res, out_res, 1'b0);
        end
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] value);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    while (gap > 0) begin
      start = 1'b0;
      gap--;
      @(negedge clk);
    end
    in_req.command    = cmd;
    in_req.push_value = value;
    start             = 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_fifo_result(in_req));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ring_length(input logic [CNT_W-1:0] len);
    wait_for_drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk); while (!cfg_ready);
    load_ring_length(len);
    length_write_count++;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom_range(63);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_sample();
    case ($urandom_range(15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic test_empty_reads();
    send_request(CMD_PEEK, 16'sh1234);
    send_request(CMD_DEQ, 16'sh7fff);
  endtask

  task automatic test_sample_extremes();
    send_request(CMD_ENQ, 16'sh7fff);
    send_request(CMD_ENQ, 16'sh8000);
    send_request(CMD_ENQ, 16'sh0000);
    send_request(CMD_ENQ, 16'shffff);
    send_request(CMD_PEEK, 16'sh0000);
    send_request(CMD_NOP, 16'sh5a5a);
    repeat (4) send_request(CMD_DEQ, 16'sh0000);
  endtask

  task automatic test_zero_length();
    write_ring_length(6'd0);
    send_request(CMD_ENQ, 16'sh0101);
    send_request(CMD_ENQ, 16'sh0202);
    send_request(CMD_PEEK, 16'sh0000);
    send_request(CMD_DEQ, 16'sh0000);
  endtask

  task automatic test_short_ring();
    write_ring_length(6'd2);
    send_request(CMD_ENQ, 16'sh0a0a);
    send_request(CMD_ENQ, 16'sh0b0b);
    send_request(CMD_ENQ, 16'sh0c0c);
    send_request(CMD_DEQ, 16'sh0000);
    send_request(CMD_DEQ, 16'sh0000);
    send_request(CMD_DEQ, 16'sh0000);
  endtask

  // Randomly pick fill, drain and mixed bursts so the ring reaches both full and empty.
  task automatic test_random_traffic(input int n_items, input logic [CNT_W-1:0] len);
    int done;
    int burst;
    int mode;
    int pick;
    logic [CMD_W-1:0] cmd;
    write_ring_length(len);
    done = 0;
    while (done < n_items) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(1, 2 * ring_size() + 2);
      for (int i = 0; i < burst && done < n_items; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          cmd = CMD_NOP;
        end else if (mode == 0) begin
          cmd = (pick < 75) ? CMD_ENQ : (pick < 90) ? CMD_DEQ : CMD_PEEK;
        end else if (mode == 1) begin
          cmd = (pick < 25) ? CMD_ENQ : (pick < 80) ? CMD_DEQ : CMD_PEEK;
        end else begin
          cmd = (pick < 45) ? CMD_ENQ : (pick < 75) ? CMD_DEQ : CMD_PEEK;
        end
        send_request(cmd, pick_sample());
        done++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    in_req             = '0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    cycle_count        = 0;
    mismatch_count     = 0;
    request_count      = 0;
    overwrite_count    = 0;
    empty_count        = 0;
    length_write_count = 0;
    sender_idle_pct    = 15;
    load_ring_length(LEN_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_reads();
    test_sample_extremes();
    test_zero_length();
    test_short_ring();

    sender_idle_pct = 15;
    test_random_traffic(200, 6'd63);
    test_random_traffic(200, 6'd1);
    test_random_traffic(150, 6'($urandom_range(3, 62)));
    sender_idle_pct = 64;
    test_random_traffic(200, 6'd5);
    test_random_traffic(200, 6'd0);
    test_random_traffic(150, 6'($urandom_range(3, 62)));
    sender_idle_pct = 0;
    test_random_traffic(200, 6'd17);
    test_random_traffic(200, 6'd63);
    test_random_traffic(100, 6'd2);

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("%0d requests over %0d ring lengths: %0d overwrites, %0d empty reads",
             request_count, length_write_count + 1, overwrite_count, empty_count);
    $display("%0d mismatches, %0d results outstanding", mismatch_count,
             expected_results.size());
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
